### design/dts_pkg.sv
// Shared types, constants and helpers for the datalog token scanner.
// No dependencies; used by dts_scan, dts_out_queue and datalog_token_scanner_top.
package dts_pkg;

    localparam int LINE_WIDTH  = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_COMMENT = 3'd1,
        PH_STRING  = 3'd2,
        PH_IDENT   = 3'd3,
        PH_COLON   = 3'd4,
        PH_HALT    = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        K_COMMA     = 4'd0,
        K_PERIOD    = 4'd1,
        K_QMARK     = 4'd2,
        K_LPAREN    = 4'd3,
        K_RPAREN    = 4'd4,
        K_COLON     = 4'd5,
        K_COLONDASH = 4'd6,
        K_STRING    = 4'd7,
        K_ID        = 4'd8,
        K_SCHEMES   = 4'd9,
        K_FACTS     = 4'd10,
        K_RULES     = 4'd11,
        K_QUERIES   = 4'd12,
        K_ERROR     = 4'd13,
        K_TOTAL     = 4'd14
    } t_kind;

    // one result item as it waits for the output side
    typedef struct packed {
        t_kind                kind;
        logic [OUT_WIDTH-1:0] start_line;
        logic [OUT_WIDTH-1:0] total_tokens;
        logic                 last;
    } t_result;

    // results caused by one accepted request, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int NUM_KW = 4;

    // Schemes, Facts, Rules, Queries
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h53, 8'h63, 8'h68, 8'h65, 8'h6D, 8'h65, 8'h73, 8'h00},
        '{8'h46, 8'h61, 8'h63, 8'h74, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h75, 8'h6C, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},
        '{8'h51, 8'h75, 8'h65, 8'h72, 8'h69, 8'h65, 8'h73, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd5, 4'd5, 4'd7};
    localparam t_kind KW_KIND [NUM_KW] = '{K_SCHEMES, K_FACTS, K_RULES, K_QUERIES};

    localparam logic [31:0] OUT_MAX = 32'((64'd1 << OUT_WIDTH) - 64'd1);

    function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [31:0] v);
        logic [31:0] r;
        r = (v > OUT_MAX) ? OUT_MAX : v;
        return r[OUT_WIDTH-1:0];
    endfunction

endpackage

### design/dts_scan.sv
// Scanner state and per-character decode: updates the scan state on each
// accepted request and produces up to two result items. Uses dts_pkg.
module dts_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_input,
    output dts_pkg::t_push     o_push
);

    typedef struct packed {
        logic            emit;
        dts_pkg::t_kind  kind;
        dts_pkg::t_phase phase;
        logic            bump;
        logic            start;
        logic            init;
    } t_idle;

    dts_pkg::t_phase                   r_phase, n_phase;
    logic [dts_pkg::LINE_WIDTH-1:0]    r_line, n_line;
    logic [dts_pkg::LINE_WIDTH-1:0]    r_start, n_start;
    logic [3:0]                        r_len, n_len;
    logic [3:0]                        r_cands, n_cands;
    logic [dts_pkg::COUNT_WIDTH-1:0]   r_total, n_total;

    logic                              is_space, is_alpha, is_alnum;
    t_idle                             dec;
    logic [3:0]                        init_cands, keep_mask;
    dts_pkg::t_kind                    id_kind;
    logic [dts_pkg::LINE_WIDTH-1:0]    line_inc;
    logic [dts_pkg::COUNT_WIDTH-1:0]   cnt_a;

    logic                              r0_v, r1_v;
    dts_pkg::t_kind                    r0_kind, r1_kind;
    logic [dts_pkg::LINE_WIDTH-1:0]    r0_line, r1_line;

    function automatic logic counted(input dts_pkg::t_kind k);
        return (k != dts_pkg::K_ERROR) && (k != dts_pkg::K_TOTAL);
    endfunction

    function automatic logic [dts_pkg::COUNT_WIDTH-1:0] cnt_inc(
        input logic [dts_pkg::COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // what a character does between tokens
    function automatic t_idle idle_scan(input logic [7:0] c, input logic sp,
                                        input logic al);
        t_idle r;
        r.emit  = 1'b0;
        r.kind  = dts_pkg::K_ERROR;
        r.phase = dts_pkg::PH_IDLE;
        r.bump  = 1'b0;
        r.start = 1'b0;
        r.init  = 1'b0;
        if (sp) begin
            r.bump = (c == dts_pkg::CH_LF) || (c == dts_pkg::CH_CR);
        end else begin
            case (c)
                dts_pkg::CH_HASH:  r.phase = dts_pkg::PH_COMMENT;
                dts_pkg::CH_COMMA: begin r.emit = 1'b1; r.kind = dts_pkg::K_COMMA;  end
                dts_pkg::CH_DOT:   begin r.emit = 1'b1; r.kind = dts_pkg::K_PERIOD; end
                dts_pkg::CH_QMARK: begin r.emit = 1'b1; r.kind = dts_pkg::K_QMARK;  end
                dts_pkg::CH_LPAR:  begin r.emit = 1'b1; r.kind = dts_pkg::K_LPAREN; end
                dts_pkg::CH_RPAR:  begin r.emit = 1'b1; r.kind = dts_pkg::K_RPAREN; end
                dts_pkg::CH_COLON: begin r.start = 1'b1; r.phase = dts_pkg::PH_COLON; end
                dts_pkg::CH_QUOTE: begin r.start = 1'b1; r.phase = dts_pkg::PH_STRING; end
                default: begin
                    if (al) begin
                        r.start = 1'b1;
                        r.init  = 1'b1;
                        r.phase = dts_pkg::PH_IDENT;
                    end else begin
                        r.emit  = 1'b1;
                        r.kind  = dts_pkg::K_ERROR;
                        r.phase = dts_pkg::PH_HALT;
                    end
                end
            endcase
        end
        return r;
    endfunction

    assign is_space = (i_char_code == dts_pkg::CH_SPACE) ||
                      ((i_char_code >= dts_pkg::CH_TAB) && (i_char_code <= dts_pkg::CH_CR));
    assign is_alpha = ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A)) ||
                      ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A));
    assign is_alnum = is_alpha || ((i_char_code >= 8'h30) && (i_char_code <= 8'h39));
    assign dec      = idle_scan(i_char_code, is_space, is_alpha);
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;

    always_comb begin
        init_cands = '0;
        keep_mask  = '0;
        id_kind    = dts_pkg::K_ID;
        for (int i = 0; i < dts_pkg::NUM_KW; i++) begin
            init_cands[i] = (dts_pkg::KW_TEXT[i][0] == i_char_code);
            keep_mask[i]  = (r_len < dts_pkg::KW_LEN[i]) &&
                            (dts_pkg::KW_TEXT[i][r_len[2:0]] == i_char_code);
            if (r_cands[i] && (r_len == dts_pkg::KW_LEN[i])) begin
                id_kind = dts_pkg::KW_KIND[i];
            end
        end
    end

    // next state
    always_comb begin
        logic use_idle;
        use_idle = 1'b0;
        n_phase  = r_phase;
        n_line   = r_line;
        n_start  = r_start;
        n_len    = r_len;
        n_cands  = r_cands;
        if (i_end_of_input) begin
            n_phase = dts_pkg::PH_HALT;
        end else begin
            case (r_phase)
                dts_pkg::PH_IDLE: use_idle = 1'b1;
                dts_pkg::PH_COMMENT: begin
                    if (i_char_code == dts_pkg::CH_LF) begin
                        n_line  = line_inc;
                        n_phase = dts_pkg::PH_IDLE;
                    end
                end
                dts_pkg::PH_STRING: begin
                    if (i_char_code == dts_pkg::CH_QUOTE) begin
                        n_phase = dts_pkg::PH_IDLE;
                    end else if (i_char_code == dts_pkg::CH_LF) begin
                        n_phase = dts_pkg::PH_HALT;
                    end
                end
                dts_pkg::PH_IDENT: begin
                    if (is_alnum) begin
                        n_cands = r_cands & keep_mask;
                        n_len   = (r_len < 4'd8) ? r_len + 4'd1 : r_len;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                dts_pkg::PH_COLON: begin
                    if (i_char_code == dts_pkg::CH_DASH) begin
                        n_phase = dts_pkg::PH_IDLE;
                    end else begin
                        use_idle = 1'b1;
                    end
                end
                default: ;
            endcase
            if (use_idle) begin
                n_phase = dec.phase;
                if (dec.bump) begin
                    n_line = line_inc;
                end
                if (dec.start) begin
                    n_start = r_line;
                end
                if (dec.init) begin
                    n_len   = 4'd1;
                    n_cands = init_cands;
                end
            end
        end
        n_total = (r1_v && counted(r1_kind)) ? cnt_inc(cnt_a) : cnt_a;
    end

    // results
    always_comb begin
        r0_v    = 1'b0;
        r0_kind = dts_pkg::K_ERROR;
        r0_line = r_line;
        r1_v    = 1'b0;
        r1_kind = dts_pkg::K_TOTAL;
        r1_line = r_line;
        if (i_end_of_input) begin
            case (r_phase)
                dts_pkg::PH_HALT: ;
                dts_pkg::PH_STRING: r0_v = 1'b1;
                dts_pkg::PH_IDENT: begin
                    r0_v    = 1'b1;
                    r0_kind = id_kind;
                    r0_line = r_start;
                    r1_v    = 1'b1;
                end
                dts_pkg::PH_COLON: begin
                    r0_v    = 1'b1;
                    r0_kind = dts_pkg::K_COLON;
                    r0_line = r_start;
                    r1_v    = 1'b1;
                end
                default: begin
                    r0_v    = 1'b1;
                    r0_kind = dts_pkg::K_TOTAL;
                end
            endcase
        end else begin
            case (r_phase)
                dts_pkg::PH_IDLE: begin
                    r0_v    = dec.emit;
                    r0_kind = dec.kind;
                end
                dts_pkg::PH_STRING: begin
                    if (i_char_code == dts_pkg::CH_QUOTE) begin
                        r0_v    = 1'b1;
                        r0_kind = dts_pkg::K_STRING;
                        r0_line = r_start;
                    end else if (i_char_code == dts_pkg::CH_LF) begin
                        r0_v = 1'b1;
                    end
                end
                dts_pkg::PH_IDENT: begin
                    if (!is_alnum) begin
                        r0_v    = 1'b1;
                        r0_kind = id_kind;
                        r0_line = r_start;
                        r1_v    = dec.emit;
                        r1_kind = dec.kind;
                    end
                end
                dts_pkg::PH_COLON: begin
                    r0_v    = 1'b1;
                    r0_line = r_start;
                    if (i_char_code == dts_pkg::CH_DASH) begin
                        r0_kind = dts_pkg::K_COLONDASH;
                    end else begin
                        r0_kind = dts_pkg::K_COLON;
                        r1_v    = dec.emit;
                        r1_kind = dec.kind;
                    end
                end
                default: ;
            endcase
        end
    end

    // running count after the first result
    assign cnt_a = (r0_v && counted(r0_kind)) ? cnt_inc(r_total) : r_total;

    always_comb begin
        o_push.count = i_accept ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;
        o_push.first.kind         = r0_kind;
        o_push.first.start_line   = dts_pkg::sat_out(32'(r0_line));
        o_push.first.total_tokens = (r0_kind == dts_pkg::K_TOTAL) ?
                                    dts_pkg::sat_out(32'(r_total)) : '0;
        o_push.first.last         = !r1_v;
        o_push.second.kind         = r1_kind;
        o_push.second.start_line   = dts_pkg::sat_out(32'(r1_line));
        o_push.second.total_tokens = (r1_kind == dts_pkg::K_TOTAL) ?
                                     dts_pkg::sat_out(32'(cnt_a)) : '0;
        o_push.second.last         = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dts_pkg::PH_IDLE;
            r_line  <= dts_pkg::LINE_WIDTH'(1);
            r_start <= '0;
            r_len   <= '0;
            r_cands <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_start <= n_start;
            r_len   <= n_len;
            r_cands <= n_cands;
            r_total <= n_total;
        end
    end

endmodule

### design/dts_out_queue.sv
// Three-entry result queue; the head entry is the output register.
// Takes up to two results per cycle; gives one if i_out_ready. Uses dts_pkg.
module dts_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dts_pkg::t_push   i_push,
    output logic             o_room,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output dts_pkg::t_result o_head
);

    dts_pkg::t_result r_q [3];
    dts_pkg::t_result n_q [3];
    dts_pkg::t_result sh  [3];
    logic [1:0]       r_cnt, n_cnt, base;
    logic             pop;

    assign o_room      = (r_cnt <= 2'd1);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_head      = r_q[0];

    always_comb begin
        pop   = o_out_valid && i_out_ready;
        sh[0] = pop ? r_q[1] : r_q[0];
        sh[1] = pop ? r_q[2] : r_q[1];
        sh[2] = r_q[2];
        base  = r_cnt - {1'b0, pop};
        for (int j = 0; j < 3; j++) begin
            n_q[j] = sh[j];
            if ((i_push.count != 2'd0) && (2'(j) == base)) begin
                n_q[j] = i_push.first;
            end else if ((i_push.count == 2'd2) && (2'(j) == base + 2'd1)) begin
                n_q[j] = i_push.second;
            end
        end
        n_cnt = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

### design/datalog_token_scanner_top.sv
// Top level of the datalog token scanner: scanner state plus result queue.
// Depends on dts_pkg, dts_scan and dts_out_queue.
//
// Streaming lexer taking one character (or an end-of-input mark) per request
// and producing token kinds with their start line. A character is taken in
// the cycle it is offered while the queue has room, so the scan runs at one
// character per cycle; the scanner state update is a single registered step.
// Results leave one per cycle while i_out_ready is high, through a
// three-entry queue whose head is the output register, and a request is
// accepted while that queue holds at most one result. A character that ends
// a pending identifier or colon and also forms a token gives two results.
// After an error token or the total token the block takes requests but gives
// nothing until reset. No startup sweep: requests are taken right after reset.
module datalog_token_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [15:0] o_total_tokens,
    output logic        o_last_of_run
);

    dts_pkg::t_push   push;
    dts_pkg::t_result head;
    logic             accept;

    assign accept = i_in_valid && o_in_ready;

    dts_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_push         (push)
    );

    dts_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_head      (head)
    );

    assign o_token_kind   = head.kind;
    assign o_start_line   = head.start_line;
    assign o_total_tokens = head.total_tokens;
    assign o_last_of_run  = head.last;

endmodule

### tb/testbench.sv
// Self-checking testbench for datalog_token_scanner_top: character stream in, tokens out.
// Depends on dts_pkg and the scanner RTL; a scoreboard class predicts and checks the tokens.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP      = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct {
        dts_pkg::t_kind kind;
        logic [15:0]    line;
        logic [15:0]    total;
        logic           last;
    } t_token_rec;

    class token_scoreboard;
        dts_pkg::t_phase                 phase;
        logic [dts_pkg::LINE_WIDTH-1:0]  line_no;
        logic [dts_pkg::LINE_WIDTH-1:0]  tok_line;
        logic [3:0]                      id_len;
        logic [3:0]                      kw_live;
        logic [dts_pkg::COUNT_WIDTH-1:0] tok_count;
        string                           kw_word [4];
        dts_pkg::t_kind                  kw_tag [4];
        t_token_rec                      due_tokens [$];
        t_token_rec                      step_tokens [$];
        int unsigned                     requests;
        int unsigned                     checked;
        int unsigned                     faults;
        logic [15:0]                     kinds_seen;

        function new();
            kw_word[0] = "Schemes";
            kw_word[1] = "Facts";
            kw_word[2] = "Rules";
            kw_word[3] = "Queries";
            kw_tag[0]  = dts_pkg::K_SCHEMES;
            kw_tag[1]  = dts_pkg::K_FACTS;
            kw_tag[2]  = dts_pkg::K_RULES;
            kw_tag[3]  = dts_pkg::K_QUERIES;
            phase      = dts_pkg::PH_IDLE;
            line_no    = 1;
            tok_line   = '0;
            id_len     = '0;
            kw_live    = '0;
            tok_count  = '0;
            requests   = 0;
            checked    = 0;
            faults     = 0;
            kinds_seen = '0;
        endfunction

        function int pending();
            return due_tokens.size();
        endfunction

        function logic [15:0] clip16(longint unsigned v);
            return (v > 64'd65535) ? 16'hFFFF : v[15:0];
        endfunction

        function void add_token(dts_pkg::t_kind k, logic [dts_pkg::LINE_WIDTH-1:0] ln);
            t_token_rec r;
            if (step_tokens.size() >= 2)
                return;
            r.kind  = k;
            r.line  = clip16(ln);
            r.total = (k == dts_pkg::K_TOTAL) ? clip16(tok_count) : 16'd0;
            r.last  = 1'b0;
            step_tokens.push_back(r);
            if (k != dts_pkg::K_ERROR && k != dts_pkg::K_TOTAL &&
                tok_count != {dts_pkg::COUNT_WIDTH{1'b1}})
                tok_count++;
        endfunction

        function void next_line();
            if (line_no != {dts_pkg::LINE_WIDTH{1'b1}})
                line_no++;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == dts_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_letnum(logic [7:0] c);
            return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
        endfunction

        function void close_ident();
            dts_pkg::t_kind k;
            k = dts_pkg::K_ID;
            for (int i = 0; i < 4; i++)
                if (kw_live[i] && id_len == 4'(kw_word[i].len()))
                    k = kw_tag[i];
            add_token(k, tok_line);
        endfunction

        // character seen between tokens
        function void idle_char(logic [7:0] c);
            if (is_blank(c)) begin
                if (c == dts_pkg::CH_LF || c == dts_pkg::CH_CR)
                    next_line();
                return;
            end
            case (c)
                dts_pkg::CH_HASH:  phase = dts_pkg::PH_COMMENT;
                dts_pkg::CH_COMMA: add_token(dts_pkg::K_COMMA, line_no);
                dts_pkg::CH_DOT:   add_token(dts_pkg::K_PERIOD, line_no);
                dts_pkg::CH_QMARK: add_token(dts_pkg::K_QMARK, line_no);
                dts_pkg::CH_LPAR:  add_token(dts_pkg::K_LPAREN, line_no);
                dts_pkg::CH_RPAR:  add_token(dts_pkg::K_RPAREN, line_no);
                dts_pkg::CH_COLON: begin
                    tok_line = line_no;
                    phase    = dts_pkg::PH_COLON;
                end
                dts_pkg::CH_QUOTE: begin
                    tok_line = line_no;
                    phase    = dts_pkg::PH_STRING;
                end
                default: begin
                    if (is_letter(c)) begin
                        tok_line = line_no;
                        id_len   = 4'd1;
                        kw_live  = '0;
                        for (int i = 0; i < 4; i++)
                            if (kw_word[i][0] == c)
                                kw_live[i] = 1'b1;
                        phase = dts_pkg::PH_IDENT;
                    end else begin
                        add_token(dts_pkg::K_ERROR, line_no);
                        phase = dts_pkg::PH_HALT;
                    end
                end
            endcase
        endfunction

        function void lex_char(logic [7:0] c);
            int p;
            case (phase)
                dts_pkg::PH_IDLE: idle_char(c);
                dts_pkg::PH_COMMENT: begin
                    if (c == dts_pkg::CH_LF) begin
                        next_line();
                        phase = dts_pkg::PH_IDLE;
                    end
                end
                dts_pkg::PH_STRING: begin
                    if (c == dts_pkg::CH_QUOTE) begin
                        add_token(dts_pkg::K_STRING, tok_line);
                        phase = dts_pkg::PH_IDLE;
                    end else if (c == dts_pkg::CH_LF) begin
                        add_token(dts_pkg::K_ERROR, line_no);
                        phase = dts_pkg::PH_HALT;
                    end
                end
                dts_pkg::PH_IDENT: begin
                    if (is_letnum(c)) begin
                        p = id_len;
                        for (int i = 0; i < 4; i++)
                            if (p >= kw_word[i].len() || kw_word[i][p] != c)
                                kw_live[i] = 1'b0;
                        if (id_len < 4'd8)
                            id_len++;
                    end else begin
                        close_ident();
                        phase = dts_pkg::PH_IDLE;
                        idle_char(c);
                    end
                end
                dts_pkg::PH_COLON: begin
                    if (c == dts_pkg::CH_DASH) begin
                        add_token(dts_pkg::K_COLONDASH, tok_line);
                        phase = dts_pkg::PH_IDLE;
                    end else begin
                        add_token(dts_pkg::K_COLON, tok_line);
                        phase = dts_pkg::PH_IDLE;
                        idle_char(c);
                    end
                end
                default: ;
            endcase
        endfunction

        function void lex_end();
            case (phase)
                dts_pkg::PH_HALT: return;
                dts_pkg::PH_STRING: begin
                    add_token(dts_pkg::K_ERROR, line_no);
                    phase = dts_pkg::PH_HALT;
                    return;
                end
                dts_pkg::PH_IDENT: close_ident();
                dts_pkg::PH_COLON: add_token(dts_pkg::K_COLON, tok_line);
                default: ;
            endcase
            add_token(dts_pkg::K_TOTAL, line_no);
            phase = dts_pkg::PH_HALT;
        endfunction

        function void note_request(logic [7:0] c, logic eoi);
            requests++;
            step_tokens.delete();
            if (eoi)
                lex_end();
            else
                lex_char(c);
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size()-1].last = 1'b1;
            foreach (step_tokens[i])
                due_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_result(logic [3:0] kind, logic [15:0] line, logic [15:0] total,
                                   logic last);
            t_token_rec want;
            if (due_tokens.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected token: kind %0d line %0d total %0d last %0d",
                             kind, line, total, last);
                return;
            end
            want = due_tokens.pop_front();
            checked++;
            kinds_seen[want.kind] = 1'b1;
            if (want.kind !== kind || want.line !== line || want.total !== total ||
                want.last !== last) begin
                faults++;
                if (faults <= 10)
                    $display("token %0d: expected kind %0d line %0d total %0d last %0d, %s",
                             checked, want.kind, want.line, want.total, want.last,
                             $sformatf("got %0d %0d %0d %0d", kind, line, total, last));
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_char_code    = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_start_line;
    logic [15:0] o_total_tokens;
    logic        o_last_of_run;

    token_scoreboard sb = new();
    bit          rst_done     = 1'b0;
    bit          no_idle      = 1'b0;
    bit          hold_out_req = 1'b0;
    int unsigned quiet_cycles = 0;

    datalog_token_scanner_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_total_tokens (o_total_tokens),
        .o_last_of_run  (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // longest legal quiet stretch is the output hold plus one gap
    always @(posedge i_clk) begin
        if (rst_done) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // output side: random stall per token, long hold on request
    initial begin
        int gap;
        wait (rst_done);
        @(negedge i_clk);
        forever begin
            if (hold_out_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out_req = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_token_kind, o_start_line, o_total_tokens, o_last_of_run);
            @(negedge i_clk);
        end
    end

    // entered and left at a falling edge
    task automatic offer(input logic [7:0] c, input logic eoi);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_code    <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(c, eoi);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer(s[i], 1'b0);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'h30 + 8'(r);
        else if (r < 36)
            return 8'h41 + 8'(r - 10);
        return 8'h61 + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? dts_pkg::CH_SPACE : dts_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 4))
            0: return dts_pkg::CH_COMMA;
            1: return dts_pkg::CH_DOT;
            2: return dts_pkg::CH_QMARK;
            3: return dts_pkg::CH_LPAR;
            default: return dts_pkg::CH_RPAR;
        endcase
    endfunction

    // any byte but newline, and but quote inside strings
    function automatic logic [7:0] rand_text_byte(input bit in_string);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == dts_pkg::CH_LF || (in_string && b == dts_pkg::CH_QUOTE));
        return b;
    endfunction

    // one well-formed token; neighbors may run together (ident into punct etc.)
    task automatic rand_token();
        int    n;
        string w;
        case ($urandom_range(0, 9))
            0, 1: offer(pick_punct(), 1'b0);
            2: begin
                offer(dts_pkg::CH_COLON, 1'b0);
                if ($urandom_range(0, 1))
                    offer(dts_pkg::CH_DASH, 1'b0);
            end
            3: begin
                offer(dts_pkg::CH_QUOTE, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) offer(rand_text_byte(1'b1), 1'b0);
                offer(dts_pkg::CH_QUOTE, 1'b0);
            end
            4: begin
                offer(dts_pkg::CH_HASH, 1'b0);
                n = $urandom_range(0, 8);
                repeat (n) offer(rand_text_byte(1'b0), 1'b0);
                offer(dts_pkg::CH_LF, 1'b0);
            end
            5, 6: begin
                offer(rand_letter(), 1'b0);
                n = $urandom_range(0, 9);
                repeat (n) offer(rand_alnum(), 1'b0);
            end
            7: begin
                w = sb.kw_word[$urandom_range(0, 3)];
                case ($urandom_range(0, 2))
                    0: send_text(w);
                    1: send_text(w.substr(0, w.len() - 2));
                    default: begin
                        send_text(w);
                        offer(rand_alnum(), 1'b0);
                    end
                endcase
            end
            default: offer(rand_blank(), 1'b0);
        endcase
    endtask

    // every halt is permanent, so exactly one way of ending is tried per run
    task automatic finish_stream(output string how);
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: begin
                send_text("Rules");
                how = "clean end with an identifier pending";
            end
            1: begin
                offer(dts_pkg::CH_COLON, 1'b0);
                how = "clean end with a colon pending";
            end
            2: begin
                offer(dts_pkg::CH_SPACE, 1'b0);
                how = "clean end between tokens";
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: b = 8'h80 + 8'($urandom_range(0, 127));
                    1: b = dts_pkg::CH_DASH;
                    2: b = 8'h30 + 8'($urandom_range(0, 9));
                    default: begin
                        do b = 8'($urandom_range(0, 127));
                        while (sb.is_letnum(b) || sb.is_blank(b) ||
                               b == dts_pkg::CH_HASH || b == dts_pkg::CH_QUOTE ||
                               b == dts_pkg::CH_COLON || b == dts_pkg::CH_COMMA ||
                               b == dts_pkg::CH_DOT || b == dts_pkg::CH_QMARK ||
                               b == dts_pkg::CH_LPAR || b == dts_pkg::CH_RPAR);
                    end
                endcase
                if (b == dts_pkg::CH_DASH || sb.is_letnum(b) || $urandom_range(0, 1))
                    offer(dts_pkg::CH_SPACE, 1'b0);
                offer(b, 1'b0);
                how = "bad start character";
            end
            4: begin
                offer(dts_pkg::CH_QUOTE, 1'b0);
                offer(rand_text_byte(1'b1), 1'b0);
                offer(dts_pkg::CH_LF, 1'b0);
                how = "string cut by newline";
            end
            default: begin
                offer(dts_pkg::CH_QUOTE, 1'b0);
                offer(rand_text_byte(1'b1), 1'b0);
                how = "string cut by end of input";
            end
        endcase
        offer(8'h00, 1'b1);
    endtask

    initial begin
        int unsigned goal;
        int          seg;
        string       how;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done  = 1'b1;

        // all kinds but error and total, ident ended by punct, colon runs, CR in string
        // and comment, byte 255 in a string, long identifier, every blank
        send_text({"Schemes Facts:-Rules,Queries.?()'a\015\377'#\015\n",
                   "Fact::SchemesQueries\t\013\014\015 "});

        goal = sb.requests + RANDOM_ITEMS;
        seg  = 0;
        while (sb.requests < goal) begin
            if (seg % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (seg == 100) begin
                // stall the output long enough to back up the input
                no_idle      = 1'b1;
                hold_out_req = 1'b1;
                repeat (24) offer(pick_punct(), 1'b0);
                no_idle      = 1'b0;
            end
            if (seg == 250)
                pause_until_drained();
            rand_token();
            seg++;
        end

        finish_stream(how);
        // halted: these are taken but give nothing
        repeat (8) offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("%0d requests sent, %0d tokens checked, %0d of 15 token kinds seen",
                 sb.requests, sb.checked, $countones(sb.kinds_seen));
        $display("random tokens with a long output hold and a full drain; ended by %s", how);
        if (sb.faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.faults);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/dts_pkg.sv
design/dts_scan.sv
design/dts_out_queue.sv
design/datalog_token_scanner_top.sv
tb/testbench.sv
